### design/lrud_pkg.sv
`timescale 1ns / 1ps

package lrud_pkg;

    localparam int ENTRIES   = 128;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int ID_BITS   = 9;
    localparam int TIME_BITS = 16;
    localparam int SIZE_W    = 14;
    localparam int INDEX_W   = 7;

    localparam int IN_FIELDS_W  = ID_BITS + 2 * TIME_BITS + SIZE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = INDEX_W + TIME_BITS + SIZE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = 2;

    typedef enum logic
    {
        OP_QUERY = 1'b0,
        OP_FILL  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_WRITE
    } state_t;

    typedef struct packed
    {
        logic [ID_BITS-1:0]   item;
        logic [TIME_BITS-1:0] upd;
        logic [TIME_BITS-1:0] acc;
        logic [SIZE_W-1:0]    bytes;
    } entry_t;

    typedef struct packed
    {
        logic item;
        logic upd;
        logic acc;
        logic bytes;
    } field_we_t;

    typedef struct packed
    {
        logic                 match;
        logic [IDX_W-1:0]     match_idx;
        logic                 have_free;
        logic [IDX_W-1:0]     free_idx;
        logic [IDX_W-1:0]     old_idx;
        logic [TIME_BITS-1:0] hit_upd;
        logic [SIZE_W-1:0]    hit_bytes;
    } scan_res_t;

    function automatic logic [INDEX_W-1:0] to_out_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W+INDEX_W-1:0] ext;
        ext = {{INDEX_W{1'b0}}, idx};
        return ext[INDEX_W-1:0];
    endfunction

endpackage

### design/lrud_mem.sv
`timescale 1ns / 1ps

module lrud_mem
    import lrud_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] wr_addr,
    input  field_we_t        wr_en,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    logic [ID_BITS-1:0]   item_mem  [ENTRIES];
    logic [TIME_BITS-1:0] upd_mem   [ENTRIES];
    logic [TIME_BITS-1:0] acc_mem   [ENTRIES];
    logic [SIZE_W-1:0]    bytes_mem [ENTRIES];
    entry_t               rd_data_reg;

    // each field has its own enable so a hit can touch one stamp alone
    always_ff @(posedge clk)
    begin
        if (wr_en.item)
        begin
            item_mem[wr_addr] <= wr_data.item;
        end
        if (wr_en.upd)
        begin
            upd_mem[wr_addr] <= wr_data.upd;
        end
        if (wr_en.acc)
        begin
            acc_mem[wr_addr] <= wr_data.acc;
        end
        if (wr_en.bytes)
        begin
            bytes_mem[wr_addr] <= wr_data.bytes;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg.item  <= item_mem[rd_addr];
            rd_data_reg.upd   <= upd_mem[rd_addr];
            rd_data_reg.acc   <= acc_mem[rd_addr];
            rd_data_reg.bytes <= bytes_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/lrud_scan.sv
`timescale 1ns / 1ps

module lrud_scan
    import lrud_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               step,
    input  logic [IDX_W-1:0]   idx,
    input  logic               ent_valid,
    input  entry_t             ent,
    input  logic [ID_BITS-1:0] key,
    output scan_res_t          res
);

    logic                 match_reg,     match_next;
    logic [IDX_W-1:0]     match_idx_reg, match_idx_next;
    logic                 have_free_reg, have_free_next;
    logic [IDX_W-1:0]     free_idx_reg,  free_idx_next;
    logic                 seen_reg,      seen_next;
    logic [TIME_BITS-1:0] oldest_reg,    oldest_next;
    logic [IDX_W-1:0]     old_idx_reg,   old_idx_next;
    logic [TIME_BITS-1:0] hit_upd_reg,   hit_upd_next;
    logic [SIZE_W-1:0]    hit_bytes_reg, hit_bytes_next;

    always_comb
    begin
        match_next     = match_reg;
        match_idx_next = match_idx_reg;
        have_free_next = have_free_reg;
        free_idx_next  = free_idx_reg;
        seen_next      = seen_reg;
        oldest_next    = oldest_reg;
        old_idx_next   = old_idx_reg;
        hit_upd_next   = hit_upd_reg;
        hit_bytes_next = hit_bytes_reg;
        if (clear)
        begin
            match_next     = 1'b0;
            have_free_next = 1'b0;
            seen_next      = 1'b0;
        end
        else if (step)
        begin
            if (ent_valid)
            begin
                if (!match_reg && ent.item == key)
                begin
                    match_next     = 1'b1;
                    match_idx_next = idx;
                    hit_upd_next   = ent.upd;
                    hit_bytes_next = ent.bytes;
                end
                // strict less keeps the lowest index on a tie
                if (!seen_reg || ent.acc < oldest_reg)
                begin
                    seen_next    = 1'b1;
                    oldest_next  = ent.acc;
                    old_idx_next = idx;
                end
            end
            else if (!have_free_reg)
            begin
                have_free_next = 1'b1;
                free_idx_next  = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg     <= 1'b0;
            have_free_reg <= 1'b0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            match_reg     <= match_next;
            have_free_reg <= have_free_next;
            seen_reg      <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        oldest_reg    <= oldest_next;
        old_idx_reg   <= old_idx_next;
        hit_upd_reg   <= hit_upd_next;
        hit_bytes_reg <= hit_bytes_next;
    end

    always_comb
    begin
        res.match     = match_reg;
        res.match_idx = match_idx_reg;
        res.have_free = have_free_reg;
        res.free_idx  = free_idx_reg;
        res.old_idx   = old_idx_reg;
        res.hit_upd   = hit_upd_reg;
        res.hit_bytes = hit_bytes_reg;
    end

endmodule

### design/lru_timestamp_cache_directory.sv
`timescale 1ns / 1ps
// A result is registered in ST_WRITE, which waits for a free output, after the scan and ST_LAST.
// One transaction at a time, taken only in ST_IDLE; its pace is set by the scan that reads
// every entry through the single read port of the entry memory, one entry a cycle.
// Reset (rst_n, asynchronous, active low) clears the valid bits and all control state;
// the entry memory needs no clearing pass and the block is ready straight after reset.

module lru_timestamp_cache_directory
    import lrud_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // item_id, now_time, update_stamp, item_size, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // entry_index, stored_update_stamp, stored_size, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // hit, evicted
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     cnt_reg;
    logic                 pipe_step_reg;
    logic [IDX_W-1:0]     pipe_idx_reg;
    logic                 pipe_valid_reg;
    logic [ENTRIES-1:0]   valid_reg;

    op_t                  op_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] upd_reg;
    logic [SIZE_W-1:0]    size_reg;

    logic                 m_valid_reg;
    logic                 hit_reg, hit_next;
    logic                 evicted_reg, evicted_next;
    logic [INDEX_W-1:0]   index_reg, index_next;
    logic [TIME_BITS-1:0] out_upd_reg, out_upd_next;
    logic [SIZE_W-1:0]    out_size_reg, out_size_next;

    logic                 accept;
    logic                 rd_en;
    logic                 commit;
    logic                 out_free;
    logic [IDX_W-1:0]     wr_addr;
    field_we_t            wr_en;
    entry_t               wr_data;
    logic                 set_valid;
    entry_t               rd_data;
    scan_res_t            res;
    logic [IDX_W-1:0]     victim;

    assign out_free = !m_valid_reg || m_axis_tready;
    assign accept   = s_axis_tvalid && s_axis_tready;

    lrud_mem u_mem
    (
        .clk     (clk),
        .wr_addr (wr_addr),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    lrud_scan u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (accept),
        .step      (pipe_step_reg),
        .idx       (pipe_idx_reg),
        .ent_valid (pipe_valid_reg),
        .ent       (rd_data),
        .key       (id_reg),
        .res       (res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        commit        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_SCAN:
            begin
                rd_en = 1'b1;
            end
            ST_LAST:
            begin
            end
            ST_WRITE:
            begin
                commit = out_free;
            end
            default:
            begin
            end
        endcase
    end

    assign victim = res.have_free ? res.free_idx : res.old_idx;

    // write back and result, both taken from the finished scan
    always_comb
    begin
        wr_addr       = res.match_idx;
        wr_en         = '0;
        wr_data.item  = id_reg;
        wr_data.upd   = upd_reg;
        wr_data.acc   = now_reg;
        wr_data.bytes = size_reg;
        set_valid     = 1'b0;
        hit_next      = res.match;
        evicted_next  = 1'b0;
        index_next    = '0;
        out_upd_next  = '0;
        out_size_next = '0;
        if (op_reg == OP_QUERY)
        begin
            if (res.match)
            begin
                wr_en.acc     = commit;
                index_next    = to_out_index(res.match_idx);
                out_upd_next  = res.hit_upd;
                out_size_next = res.hit_bytes;
            end
        end
        else if (res.match)
        begin
            wr_en.upd  = commit;
            index_next = to_out_index(res.match_idx);
        end
        else
        begin
            wr_addr      = victim;
            wr_en        = '{item: commit, upd: commit, acc: commit, bytes: commit};
            set_valid    = commit;
            index_next   = to_out_index(victim);
            evicted_next = !res.have_free;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pipe_step_reg <= 1'b0;
            valid_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pipe_step_reg <= rd_en;
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (set_valid)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (commit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg   <= cnt_reg;
        pipe_valid_reg <= valid_reg[cnt_reg];
        if (accept)
        begin
            op_reg   <= op_t'(s_axis_tuser);
            id_reg   <= s_axis_tdata[ID_BITS-1:0];
            now_reg  <= s_axis_tdata[ID_BITS +: TIME_BITS];
            upd_reg  <= s_axis_tdata[ID_BITS+TIME_BITS +: TIME_BITS];
            size_reg <= s_axis_tdata[ID_BITS+2*TIME_BITS +: SIZE_W];
        end
        if (commit)
        begin
            hit_reg      <= hit_next;
            evicted_reg  <= evicted_next;
            index_reg    <= index_next;
            out_upd_reg  <= out_upd_next;
            out_size_reg <= out_size_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                            out_size_reg, out_upd_reg, index_reg};
    assign m_axis_tuser  = {evicted_reg, hit_reg};

endmodule
